@@ src/brs_pkg.sv @@
// shared types and constants of the balance robot supervisor
`timescale 1ns / 1ps
package brs_pkg;

	// supervisor modes
	localparam logic [2:0] MODE_INIT      = 3'd0;
	localparam logic [2:0] MODE_CALIBRATE = 3'd1;
	localparam logic [2:0] MODE_IDLE      = 3'd2;
	localparam logic [2:0] MODE_STARTING  = 3'd3;
	localparam logic [2:0] MODE_ACTIVE    = 3'd4;
	localparam logic [2:0] MODE_MOVING    = 3'd5;
	localparam logic [2:0] MODE_FAULT     = 3'd6;

	// input kinds
	localparam logic [1:0] ACT_TICK      = 2'd0;
	localparam logic [1:0] ACT_START     = 2'd1;
	localparam logic [1:0] ACT_STOP      = 2'd2;
	localparam logic [1:0] ACT_CALIBRATE = 2'd3;

	// imu commands
	localparam logic [1:0] IMU_NONE      = 2'd0;
	localparam logic [1:0] IMU_INIT      = 2'd1;
	localparam logic [1:0] IMU_CALIBRATE = 2'd2;
	localparam logic [1:0] IMU_READ      = 2'd3;

	// motor commands
	localparam logic [1:0] MOTOR_NONE    = 2'd0;
	localparam logic [1:0] MOTOR_STOP    = 2'd1;
	localparam logic [1:0] MOTOR_SPEED   = 2'd2;
	localparam logic [1:0] MOTOR_BALANCE = 2'd3;

	// configuration register indexes
	localparam logic [2:0] CFG_PITCH_SETPOINT = 3'd0;
	localparam logic [2:0] CFG_PROP_GAIN      = 3'd1;
	localparam logic [2:0] CFG_DERIV_GAIN     = 3'd2;
	localparam logic [2:0] CFG_FAILSAFE_LIMIT = 3'd3;
	localparam logic [2:0] CFG_STEPS_PER_REV  = 3'd4;

	// timing and limits
	localparam logic [31:0] RAMP_MS       = 32'd2000;
	localparam logic [31:0] RECOVER_MS    = 32'd3000;
	localparam logic [14:0] RECOVER_PITCH = 15'd960;

	// full torque in units of 1/32768000, equals 2^20 * 3125
	localparam logic signed [47:0] TORQUE_FULL = 48'sd3276800000;
	localparam logic [31:0]        TORQUE_MAG  = 32'd3276800000;
	localparam int                 DIV_SHIFT   = 20;
	localparam logic [11:0]        DIV_ODD     = 12'd3125;
	// floor(2^42 / 3125), quotient estimate is exact or one low
	localparam logic [30:0]        RECIP_M     = 31'd1407374883;
	localparam int                 RECIP_SHIFT = 42;
	localparam int                 QUOT_W      = 18;

	typedef struct packed {
		logic [14:0] pitch_setpoint;
		logic [15:0] prop_gain;
		logic [15:0] deriv_gain;
		logic [13:0] failsafe_limit;
		logic [15:0] steps_per_rev;
	} brs_cfg_t;

	// sequencer to datapath
	typedef struct packed {
		logic capture;
		logic ld_a;
		logic ld_b;
		logic ld_x;
		logic ld_mag;
		logic ld_p;
		logic ld_q;
		logic ld_c;
		logic commit;
	} brs_cmd_t;

	// datapath to sequencer
	typedef struct packed {
		logic out_free;
	} brs_stat_t;

endpackage

@@ src/brs_ctrl.sv @@
// sequencer that steps one item through the ramp arithmetic and commits it
`timescale 1ns / 1ps
module brs_ctrl import brs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  brs_stat_t stat,
	output brs_cmd_t  cmd
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_MUL_A = 4'd1;
	localparam logic [3:0] ST_MUL_B = 4'd2;
	localparam logic [3:0] ST_MUL_X = 4'd3;
	localparam logic [3:0] ST_CLAMP = 4'd4;
	localparam logic [3:0] ST_MUL_P = 4'd5;
	localparam logic [3:0] ST_MUL_Q = 4'd6;
	localparam logic [3:0] ST_MUL_C = 4'd7;
	localparam logic [3:0] ST_DONE  = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_MUL_A;
				end
			end
			ST_MUL_A: begin
				cmd.ld_a = 1'b1;
				state_d  = ST_MUL_B;
			end
			ST_MUL_B: begin
				cmd.ld_b = 1'b1;
				state_d  = ST_MUL_X;
			end
			ST_MUL_X: begin
				cmd.ld_x = 1'b1;
				state_d  = ST_CLAMP;
			end
			ST_CLAMP: begin
				cmd.ld_mag = 1'b1;
				state_d    = ST_MUL_P;
			end
			ST_MUL_P: begin
				cmd.ld_p = 1'b1;
				state_d  = ST_MUL_Q;
			end
			ST_MUL_Q: begin
				cmd.ld_q = 1'b1;
				state_d  = ST_MUL_C;
			end
			ST_MUL_C: begin
				cmd.ld_c = 1'b1;
				state_d  = ST_DONE;
			end
			ST_DONE: begin
				// wait for room in the output register
				if (stat.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ src/brs_dpath.sv @@
// supervisor state, ramp speed arithmetic and output register
`timescale 1ns / 1ps
module brs_dpath import brs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  brs_cfg_t    cfg,
	input  brs_cmd_t    cmd,
	output brs_stat_t   stat,
	input  logic [63:0] in_data,
	input  logic [1:0]  in_user,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] out_data
);

	// captured item
	logic [1:0]         act_q;
	logic [31:0]        now_q;
	logic signed [14:0] pitch_q;
	logic signed [15:0] rate_q;
	logic               imu_ok_q;

	// arithmetic chain
	logic signed [33:0] a_q;
	logic signed [33:0] b_q;
	logic signed [47:0] x_q;
	logic [31:0]        mag_q;
	logic               neg_q;
	logic [49:0]        p_q;
	logic [QUOT_W-1:0]  q0_q;
	logic [29:0]        c_q;

	// supervisor state
	logic [2:0]  mode_q;
	logic [31:0] entry_q;
	logic [31:0] rec_start_q;
	logic        armed_q;

	// output register
	logic        out_valid_q;
	logic [31:0] out_data_q;

	logic [31:0]        t_elapsed;
	logic signed [16:0] dg_s;
	logic signed [16:0] pg_s;
	logic signed [16:0] rate_s;
	logic signed [16:0] err_s;
	logic signed [33:0] a_full;
	logic signed [33:0] b_full;
	logic signed [35:0] n_sum;
	logic signed [11:0] t_s;
	logic signed [47:0] x_full;
	logic signed [47:0] x_neg;
	logic [17:0]        spr3;
	logic [49:0]        p_full;
	logic [29:0]        v_hi;
	logic [60:0]        qm_full;
	logic [29:0]        c_full;
	logic [29:0]        rem;
	logic [QUOT_W-1:0]  q_fix;
	logic [18:0]        speed;

	logic [14:0] apitch;
	logic [2:0]  mode_d;
	logic        do_enter;
	logic [1:0]  imu_cmd;
	logic [1:0]  motor_cmd;
	logic        use_speed;
	logic        clr;
	logic        pf;
	logic        armed_d;
	logic        rec_ld;

	assign t_elapsed = now_q - entry_q;

	// ramp arithmetic: x = t * (4*kd*rate - kp*err), clamped, then scaled
	assign dg_s    = $signed({1'b0, cfg.deriv_gain});
	assign pg_s    = $signed({1'b0, cfg.prop_gain});
	assign rate_s  = $signed({rate_q[15], rate_q});
	assign err_s   = $signed({{2{cfg.pitch_setpoint[14]}}, cfg.pitch_setpoint})
	               - $signed({{2{pitch_q[14]}}, pitch_q});
	assign a_full  = dg_s * rate_s;
	assign b_full  = pg_s * err_s;
	assign n_sum   = $signed({a_q, 2'b00}) - $signed({{2{b_q[33]}}, b_q});
	assign t_s     = $signed({1'b0, t_elapsed[10:0]});
	assign x_full  = t_s * n_sum;
	assign x_neg   = -x_q;
	assign spr3    = {2'b00, cfg.steps_per_rev} + {1'b0, cfg.steps_per_rev, 1'b0};
	assign p_full  = mag_q * spr3;
	assign v_hi    = p_q[49:DIV_SHIFT];
	assign qm_full = v_hi * RECIP_M;
	assign c_full  = q0_q * DIV_ODD;
	assign rem     = v_hi - c_q;
	assign q_fix   = (rem >= {18'd0, DIV_ODD}) ? q0_q + 1'b1 : q0_q;
	assign speed   = neg_q ? -{1'b0, q_fix} : {1'b0, q_fix};

	assign apitch = pitch_q[14] ? (~pitch_q + 1'b1) : pitch_q;

	// mode decisions
	always_comb begin
		mode_d    = mode_q;
		do_enter  = 1'b0;
		imu_cmd   = IMU_NONE;
		motor_cmd = MOTOR_NONE;
		use_speed = 1'b0;
		clr       = 1'b0;
		pf        = 1'b0;
		armed_d   = armed_q;
		rec_ld    = 1'b0;
		unique case (act_q)
			ACT_TICK: begin
				unique case (mode_q)
					MODE_INIT: begin
						imu_cmd = IMU_INIT;
						if (imu_ok_q) begin
							mode_d   = MODE_CALIBRATE;
							do_enter = 1'b1;
						end
					end
					MODE_CALIBRATE: begin
						imu_cmd   = IMU_CALIBRATE;
						mode_d    = MODE_IDLE;
						do_enter  = 1'b1;
						motor_cmd = MOTOR_STOP;
						clr       = 1'b1;
					end
					MODE_IDLE: begin
						imu_cmd = IMU_READ;
					end
					MODE_STARTING: begin
						imu_cmd = IMU_READ;
						if (t_elapsed >= RAMP_MS) begin
							mode_d   = MODE_ACTIVE;
							do_enter = 1'b1;
						end else begin
							use_speed = 1'b1;
							motor_cmd = MOTOR_SPEED;
						end
					end
					MODE_ACTIVE, MODE_MOVING: begin
						imu_cmd = IMU_READ;
						if (apitch > {1'b0, cfg.failsafe_limit}) begin
							mode_d    = MODE_FAULT;
							do_enter  = 1'b1;
							motor_cmd = MOTOR_STOP;
							pf        = 1'b1;
						end else begin
							motor_cmd = MOTOR_BALANCE;
						end
					end
					MODE_FAULT: begin
						motor_cmd = MOTOR_STOP;
						if (apitch < RECOVER_PITCH) begin
							if (!armed_q) begin
								armed_d = 1'b1;
								rec_ld  = 1'b1;
							end else if ((now_q - rec_start_q) > RECOVER_MS) begin
								armed_d  = 1'b0;
								clr      = 1'b1;
								mode_d   = MODE_IDLE;
								do_enter = 1'b1;
							end
						end else begin
							armed_d = 1'b0;
						end
					end
					default: begin
					end
				endcase
			end
			ACT_START: begin
				if (mode_q == MODE_IDLE) begin
					clr      = 1'b1;
					mode_d   = MODE_STARTING;
					do_enter = 1'b1;
				end
			end
			ACT_STOP: begin
				if (mode_q == MODE_ACTIVE || mode_q == MODE_MOVING ||
				    mode_q == MODE_STARTING) begin
					mode_d    = MODE_IDLE;
					do_enter  = 1'b1;
					motor_cmd = MOTOR_STOP;
					clr       = 1'b1;
				end
			end
			ACT_CALIBRATE: begin
				if (mode_q == MODE_IDLE) begin
					mode_d   = MODE_CALIBRATE;
					do_enter = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			now_q    <= in_data[31:0];
			pitch_q  <= $signed(in_data[46:32]);
			rate_q   <= $signed(in_data[62:47]);
			imu_ok_q <= in_data[63];
			act_q    <= in_user;
		end
		if (cmd.ld_a) begin
			a_q <= a_full;
		end
		if (cmd.ld_b) begin
			b_q <= b_full;
		end
		if (cmd.ld_x) begin
			x_q <= x_full;
		end
		if (cmd.ld_mag) begin
			if (x_q > TORQUE_FULL) begin
				mag_q <= TORQUE_MAG;
				neg_q <= 1'b0;
			end else if (x_q < -TORQUE_FULL) begin
				mag_q <= TORQUE_MAG;
				neg_q <= 1'b1;
			end else begin
				mag_q <= x_q[47] ? x_neg[31:0] : x_q[31:0];
				neg_q <= x_q[47];
			end
		end
		if (cmd.ld_p) begin
			p_q <= p_full;
		end
		if (cmd.ld_q) begin
			q0_q <= qm_full[RECIP_SHIFT +: QUOT_W];
		end
		if (cmd.ld_c) begin
			c_q <= c_full;
		end
		if (cmd.commit) begin
			// mode_before, mode_after, imu, motor, speed, clear, fault, pad
			out_data_q <= {1'b0, pf, clr, (use_speed ? speed : 19'd0),
			               motor_cmd, imu_cmd, mode_d, mode_q};
		end
	end

	// supervisor state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_INIT;
			entry_q     <= '0;
			rec_start_q <= '0;
			armed_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				mode_q  <= mode_d;
				armed_q <= armed_d;
				if (do_enter) begin
					entry_q <= now_q;
				end
				if (rec_ld) begin
					rec_start_q <= now_q;
				end
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.out_free = !out_valid_q || out_ready;
	assign out_valid     = out_valid_q;
	assign out_data      = out_data_q;

endmodule

@@ src/balance_robot_supervisor_top.sv @@
// top level of the balance robot supervisor
`timescale 1ns / 1ps
// balance robot supervisor: takes one item at a time on the slave stream and
// returns exactly one result item for it. an item is either a control tick
// (timestamp, pitch, pitch rate, imu-ok flag) or a start, stop or calibrate
// request, told apart by tuser. the block tracks the modes init, calibrate,
// idle, starting, active, moving and fault and reports the mode before and
// after the item plus the imu and motor commands. in starting mode it works
// out the ramp wheel speed through a chain of registered multiplications
// run by a small sequencer. the item is captured at its accepting edge and its
// result enters the output register after seven arithmetic steps and one
// commit; a new item is taken only once that result has been committed.
// a result is committed only once the output register is free: while the
// previous result is still held there, the sequencer waits in its last step
// and every cycle of that wait adds to the item's time. tready is high only
// while no item is in flight. configuration registers are written through
// the plain write port and should only change while the block is idle.
module balance_robot_supervisor_top import brs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// input items
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // now_ms[31:0], pitch[46:32], pitch_rate[62:47], imu_ok[63]
	input  logic [1:0]  s_axis_tuser,  // action[1:0]
	// result items
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // mode_before[2:0], mode_after[5:3], imu_command[7:6],
	                                   // motor_command[9:8], wheel_speed[28:10],
	                                   // clear_integral[29], pitch_fault[30], zero[31]
	// configuration write port
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	brs_cfg_t  cfg_q;
	brs_cmd_t  cmd;
	brs_stat_t stat;

	// configuration registers, indexes beyond the list are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pitch_setpoint <= 15'd0;
			cfg_q.prop_gain      <= 16'd2560;
			cfg_q.deriv_gain     <= 16'd128;
			cfg_q.failsafe_limit <= 14'd1920;
			cfg_q.steps_per_rev  <= 16'd200;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PITCH_SETPOINT: cfg_q.pitch_setpoint <= cfg_data[14:0];
				CFG_PROP_GAIN:      cfg_q.prop_gain      <= cfg_data;
				CFG_DERIV_GAIN:     cfg_q.deriv_gain     <= cfg_data;
				CFG_FAILSAFE_LIMIT: cfg_q.failsafe_limit <= cfg_data[13:0];
				CFG_STEPS_PER_REV:  cfg_q.steps_per_rev  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// sequencer: capture, arithmetic steps, commit
	brs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// mode state, ramp arithmetic and the output register
	brs_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd       (cmd),
		.stat      (stat),
		.in_data   (s_axis_tdata),
		.in_user   (s_axis_tuser),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule

@@ src/brs_checker.sv @@
// port-level checks of the balance robot supervisor and their binding
`timescale 1ns / 1ps
module brs_checker import brs_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata
);

	logic [2:0] last_mode_q;
	logic       seen_q;

	// mode_after of the last delivered item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_mode_q <= MODE_INIT;
			seen_q      <= 1'b0;
		end else if (m_axis_tvalid && m_axis_tready) begin
			last_mode_q <= m_axis_tdata[5:3];
			seen_q      <= 1'b1;
		end
	end

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
		else $error("result withdrawn while stalled");

	// one item in flight at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("item accepted while another is in flight");

	// modes chain from one result to the next
	a_mode_chain: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && seen_q) |-> (m_axis_tdata[2:0] == last_mode_q))
		else $error("mode_before does not follow previous mode_after");

	// speed only with a set-speed command
	a_speed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[9:8] == MOTOR_SPEED || m_axis_tdata[28:10] == 19'd0))
		else $error("wheel speed without set-speed command");

	// a pitch fault always lands in fault mode
	a_fault_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[30]) |-> (m_axis_tdata[5:3] == MODE_FAULT))
		else $error("pitch fault without fault mode");

endmodule

bind balance_robot_supervisor_top brs_checker u_brs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

@@ test/brs_result_checker.sv @@
// result checker of the balance robot supervisor: predicts every result item and compares
`timescale 1ns / 1ps
module brs_result_checker import brs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,
	input  logic [1:0]  s_axis_tuser,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [31:0] m_axis_tdata,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          fail_count,
	output int          pending,
	output logic [2:0]  predicted_mode
);

	// laid out as the result tdata, last member in the lowest bits
	typedef struct packed {
		logic               pitch_fault;
		logic               clear_integral;
		logic signed [18:0] wheel_speed;
		logic [1:0]         motor_cmd;
		logic [1:0]         imu_cmd;
		logic [2:0]         mode_after;
		logic [2:0]         mode_before;
	} command_set_t;

	brs_cfg_t     settings;
	logic [2:0]   mode;
	logic [31:0]  entered_ms;
	logic [31:0]  settle_start_ms;
	logic         settle_armed;
	command_set_t due_commands[$];
	int           items_in;
	int           items_out;
	int           results_seen;

	assign pending = items_in - items_out;

	task automatic report_fault(string msg);
		$display("%0t ns: %s", $time, msg);
		fail_count++;
	endtask

	task automatic check_field(string name, logic signed [31:0] seen, logic signed [31:0] wanted);
		if (seen !== wanted)
			report_fault($sformatf("result %0d: %s is %0d, predicted %0d",
				results_seen, name, seen, wanted));
	endtask

	function automatic void change_mode(logic [2:0] next, logic [31:0] now);
		mode = next;
		entered_ms = now;
	endfunction

	// pd torque over the ramp, clamped to full torque, scaled to steps and truncated
	function automatic logic signed [18:0] ramp_speed_of(logic [31:0] elapsed,
			logic signed [14:0] tilt, logic signed [15:0] rate);
		longint full;
		longint err;
		longint drive;
		longint torque;
		longint steps;
		full   = longint'(TORQUE_FULL);
		err    = longint'($signed(settings.pitch_setpoint)) - longint'(tilt);
		drive  = 4 * longint'(settings.deriv_gain) * longint'(rate)
			- longint'(settings.prop_gain) * err;
		torque = longint'(elapsed) * drive;
		if (torque > full)
			torque = full;
		if (torque < -full)
			torque = -full;
		steps = (torque < 0 ? -torque : torque) * 3 * longint'(settings.steps_per_rev) / full;
		return 19'(torque < 0 ? -steps : steps);
	endfunction

	function automatic command_set_t supervise_item(logic [1:0] act, logic [31:0] now,
			logic signed [14:0] tilt, logic signed [15:0] rate, logic imu_ok);
		command_set_t c;
		int           tilt_mag;
		logic [31:0]  elapsed;
		c = '0;
		c.mode_before = mode;
		tilt_mag = (tilt < 0) ? -int'(tilt) : int'(tilt);
		case (act)
			ACT_TICK: begin
				case (mode)
					MODE_INIT: begin
						c.imu_cmd = IMU_INIT;
						if (imu_ok)
							change_mode(MODE_CALIBRATE, now);
					end
					MODE_CALIBRATE: begin
						c.imu_cmd = IMU_CALIBRATE;
						c.motor_cmd = MOTOR_STOP;
						c.clear_integral = 1'b1;
						change_mode(MODE_IDLE, now);
					end
					MODE_IDLE: c.imu_cmd = IMU_READ;
					MODE_STARTING: begin
						c.imu_cmd = IMU_READ;
						elapsed = now - entered_ms;
						if (elapsed >= RAMP_MS) begin
							change_mode(MODE_ACTIVE, now);
						end else begin
							c.wheel_speed = ramp_speed_of(elapsed, tilt, rate);
							c.motor_cmd = MOTOR_SPEED;
						end
					end
					MODE_ACTIVE, MODE_MOVING: begin
						c.imu_cmd = IMU_READ;
						if (tilt_mag > int'(settings.failsafe_limit)) begin
							c.motor_cmd = MOTOR_STOP;
							c.pitch_fault = 1'b1;
							change_mode(MODE_FAULT, now);
						end else begin
							c.motor_cmd = MOTOR_BALANCE;
						end
					end
					MODE_FAULT: begin
						c.motor_cmd = MOTOR_STOP;
						elapsed = now - settle_start_ms;
						if (tilt_mag >= int'(RECOVER_PITCH)) begin
							settle_armed = 1'b0;
						end else if (!settle_armed) begin
							settle_armed = 1'b1;
							settle_start_ms = now;
						end else if (elapsed > RECOVER_MS) begin
							settle_armed = 1'b0;
							c.clear_integral = 1'b1;
							change_mode(MODE_IDLE, now);
						end
					end
					default: ;
				endcase
			end
			ACT_START: begin
				if (mode == MODE_IDLE) begin
					c.clear_integral = 1'b1;
					change_mode(MODE_STARTING, now);
				end
			end
			ACT_STOP: begin
				if (mode == MODE_STARTING || mode == MODE_ACTIVE || mode == MODE_MOVING) begin
					c.motor_cmd = MOTOR_STOP;
					c.clear_integral = 1'b1;
					change_mode(MODE_IDLE, now);
				end
			end
			default: begin
				if (mode == MODE_IDLE)
					change_mode(MODE_CALIBRATE, now);
			end
		endcase
		c.mode_after = mode;
		return c;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		command_set_t got;
		command_set_t want;
		if (!arst_n) begin
			settings.pitch_setpoint = 15'd0;
			settings.prop_gain      = 16'd2560;
			settings.deriv_gain     = 16'd128;
			settings.failsafe_limit = 14'd1920;
			settings.steps_per_rev  = 16'd200;
			mode            = MODE_INIT;
			entered_ms      = '0;
			settle_start_ms = '0;
			settle_armed    = 1'b0;
			due_commands.delete();
			fail_count      = 0;
			results_seen    = 0;
			items_in       <= 0;
			items_out      <= 0;
			predicted_mode <= MODE_INIT;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				items_out <= items_out + 1;
				if (due_commands.size() == 0) begin
					report_fault($sformatf("result item %h with no prediction waiting",
						m_axis_tdata));
				end else begin
					got  = command_set_t'(m_axis_tdata[30:0]);
					want = due_commands.pop_front();
					check_field("mode_before", got.mode_before, want.mode_before);
					check_field("mode_after", got.mode_after, want.mode_after);
					check_field("imu_command", got.imu_cmd, want.imu_cmd);
					check_field("motor_command", got.motor_cmd, want.motor_cmd);
					check_field("wheel_speed", got.wheel_speed, want.wheel_speed);
					check_field("clear_integral", got.clear_integral, want.clear_integral);
					check_field("pitch_fault", got.pitch_fault, want.pitch_fault);
					check_field("padding bit", m_axis_tdata[31], 1'b0);
				end
				results_seen++;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				due_commands.push_back(supervise_item(s_axis_tuser, s_axis_tdata[31:0],
					s_axis_tdata[46:32], s_axis_tdata[62:47], s_axis_tdata[63]));
				items_in       <= items_in + 1;
				predicted_mode <= mode;
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_PITCH_SETPOINT: settings.pitch_setpoint = cfg_data[14:0];
					CFG_PROP_GAIN:      settings.prop_gain      = cfg_data;
					CFG_DERIV_GAIN:     settings.deriv_gain     = cfg_data;
					CFG_FAILSAFE_LIMIT: settings.failsafe_limit = cfg_data[13:0];
					CFG_STEPS_PER_REV:  settings.steps_per_rev  = cfg_data;
					default: ;
				endcase
			end
		end
	end

endmodule

@@ test/tb_balance_robot_supervisor_top.sv @@
// testbench top of the balance robot supervisor: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module tb_balance_robot_supervisor_top;
	import brs_pkg::*;

	localparam int ITEMS_PER_PHASE = 125;  // six setting phases, about 750 items in all
	localparam int SETTING_PHASES  = 6;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata  = '0;  // now_ms[31:0], pitch[46:32], pitch_rate[62:47], imu_ok[63]
	logic [1:0]  s_axis_tuser  = ACT_TICK;  // action[1:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;  // mode_before[2:0], mode_after[5:3], imu_command[7:6],
	                            // motor_command[9:8], wheel_speed[28:10],
	                            // clear_integral[29], pitch_fault[30], zero[31]
	logic        cfg_we        = 1'b0;
	logic [2:0]  cfg_index     = CFG_PITCH_SETPOINT;
	logic [15:0] cfg_data      = '0;

	int          fail_count;
	int          pending;
	logic [2:0]  predicted_mode;

	logic [31:0] clock_ms    = 32'd1000;  // running timestamp of the control ticks
	int          tilt_limit  = 1920;      // failsafe limit as last written
	bit          steady_flow = 1'b0;      // no idling on either side while set
	int          counted     = 0;         // items of the current phase that do something

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	balance_robot_supervisor_top i_dut (.*);

	brs_result_checker i_checker (.*);

	// hard stop well beyond the slowest correct run
	initial begin
		#6ms;
		$display("** balance_robot_supervisor_top: FAILED **");
		$finish;
	end

	// mostly short gaps, now and then a long one, none in a steady stretch
	function automatic int idle_cycles();
		int roll;
		roll = $urandom_range(0, 99);
		if (steady_flow || roll < 55)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int tilt_within(int bound);
		return int'($urandom_range(0, 2 * bound)) - bound;
	endfunction

	// just past the bound, with either sign
	function automatic int tilt_beyond(int bound);
		int mag;
		mag = bound + 1 + int'($urandom_range(0, 400));
		if (mag > 11520)
			mag = (bound < 11520) ? 11520 : 16383;
		return $urandom_range(0, 1) ? -mag : mag;
	endfunction

	// small angles keep the ramp torque below its clamp, large ones reach it
	function automatic int mixed_tilt();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return tilt_within(200);
		if (roll < 90)
			return tilt_within(11520);
		return int'($urandom_range(0, 32767)) - 16384;
	endfunction

	function automatic int mixed_rate();
		if ($urandom_range(0, 1))
			return int'($urandom_range(0, 65535)) - 32768;
		return tilt_within(300);
	endfunction

	// slave side: hold one item until the block takes it
	task automatic push_item(logic [1:0] act, logic [31:0] now, int tilt, int rate, bit ok);
		int gap;
		gap = idle_cycles();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tuser  <= act;
		s_axis_tdata  <= {ok, 16'(rate), 15'(tilt), now};
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	task automatic tick_after(int advance, int tilt, int rate, bit ok);
		clock_ms += advance;
		push_item(ACT_TICK, clock_ms, tilt, rate, ok);
		counted++;
	endtask

	// requests carry random pitch fields, which the block ignores
	task automatic ask(logic [1:0] act, bit takes_effect);
		push_item(act, clock_ms, mixed_tilt(), mixed_rate(), 1'($urandom_range(0, 1)));
		if (takes_effect)
			counted++;
	endtask

	task automatic wait_drained();
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// all five registers, back to back, only while nothing is in flight
	task automatic load_settings(int setpoint, int kp, int kd, int limit, int spr);
		tilt_limit = limit & 16'h3fff;
		cfg_we    <= 1'b1;
		cfg_index <= CFG_PITCH_SETPOINT;
		cfg_data  <= 16'(setpoint);
		@(posedge clk);
		cfg_index <= CFG_PROP_GAIN;
		cfg_data  <= 16'(kp);
		@(posedge clk);
		cfg_index <= CFG_DERIV_GAIN;
		cfg_data  <= 16'(kd);
		@(posedge clk);
		cfg_index <= CFG_FAILSAFE_LIMIT;
		cfg_data  <= 16'(limit);
		@(posedge clk);
		cfg_index <= CFG_STEPS_PER_REV;
		cfg_data  <= 16'(spr);
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// one well-formed run of items chosen from the mode the block has settled in
	task automatic run_burst();
		int roll;
		steady_flow = ($urandom_range(0, 4) == 0);
		roll = $urandom_range(0, 99);
		case (predicted_mode)
			MODE_INIT: begin
				// imu mostly comes up, sometimes needs retries
				repeat ($urandom_range(1, 3))
					tick_after($urandom_range(1, 50), mixed_tilt(), mixed_rate(),
						$urandom_range(0, 9) < 7);
			end
			MODE_CALIBRATE: tick_after($urandom_range(1, 50), mixed_tilt(), mixed_rate(), 1'b1);
			MODE_IDLE: begin
				if (roll < 70) begin
					// start a ramp, sometimes at a random time or just before the wrap
					if ($urandom_range(0, 3) == 0)
						clock_ms = $urandom;
					else if ($urandom_range(0, 9) == 0)
						clock_ms = 32'hffff_ffff - $urandom_range(0, 1500);
					ask(ACT_START, 1'b1);
					repeat ($urandom_range(2, 10)) begin
						if ($urandom_range(0, 19) == 0)
							ask(ACT_STOP, 1'b1);
						else
							tick_after($urandom_range(0, 450), mixed_tilt(), mixed_rate(),
								1'($urandom_range(0, 1)));
					end
				end else if (roll < 85) begin
					ask(ACT_CALIBRATE, 1'b1);
					tick_after($urandom_range(1, 50), mixed_tilt(), mixed_rate(), 1'b1);
				end else begin
					// idle ticks and a stray stop
					ask(ACT_STOP, 1'b0);
					repeat ($urandom_range(1, 3))
						tick_after($urandom_range(1, 100), mixed_tilt(), mixed_rate(),
							1'($urandom_range(0, 1)));
				end
			end
			MODE_STARTING: begin
				repeat ($urandom_range(1, 6)) begin
					if ($urandom_range(0, 9) == 0)
						ask(ACT_STOP, 1'b1);
					else
						tick_after($urandom_range(50, 700), mixed_tilt(), mixed_rate(),
							1'($urandom_range(0, 1)));
				end
			end
			MODE_ACTIVE, MODE_MOVING: begin
				// balancing, with the odd stop or tilt past the failsafe limit
				repeat ($urandom_range(2, 12)) begin
					roll = $urandom_range(0, 99);
					if (roll < 8)
						ask(ACT_STOP, 1'b1);
					else if (roll < 20)
						tick_after($urandom_range(1, 20), tilt_beyond(tilt_limit), mixed_rate(),
							1'($urandom_range(0, 1)));
					else
						tick_after($urandom_range(1, 20), tilt_within(tilt_limit), mixed_rate(),
							1'($urandom_range(0, 1)));
				end
			end
			MODE_FAULT: begin
				// settling back below the recovery angle, now and then knocked over again
				repeat ($urandom_range(3, 10)) begin
					roll = $urandom_range(0, 99);
					if (roll < 5)
						ask($urandom_range(0, 1) ? ACT_START : ACT_CALIBRATE, 1'b0);
					else if (roll < 20)
						tick_after($urandom_range(100, 1600), tilt_beyond(959), mixed_rate(),
							1'($urandom_range(0, 1)));
					else
						tick_after($urandom_range(100, 1600), tilt_within(959), mixed_rate(),
							1'($urandom_range(0, 1)));
				end
			end
			default: tick_after(1, mixed_tilt(), mixed_rate(), 1'b1);
		endcase
		// an occasional item with every field random
		if ($urandom_range(0, 6) == 0)
			push_item(2'($urandom_range(0, 3)), $urandom, int'($urandom_range(0, 32767)),
				int'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
		s_axis_tvalid <= 1'b0;
	endtask

	// master side: random stalls, with steady stretches
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = idle_cycles();
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	end

	initial begin
		int phase;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed walk through every mode with the reset settings
		tick_after(5, 0, 0, 1'b0);              // imu not ready, stays in init
		ask(ACT_START, 1'b0);                   // start ignored outside idle
		tick_after(5, 100, -50, 1'b1);          // imu up, on to calibrate
		ask(ACT_CALIBRATE, 1'b0);               // ignored while calibrating
		tick_after(5, 0, 0, 1'b0);              // calibrate done, idle
		ask(ACT_STOP, 1'b0);                    // stop ignored in idle
		ask(ACT_CALIBRATE, 1'b1);               // recalibrate from idle
		tick_after(5, -16384, 32767, 1'b1);
		clock_ms = 32'hffff_ff00;               // ramp runs across the timestamp wrap
		ask(ACT_START, 1'b1);
		tick_after(0, 11520, 32767, 1'b1);      // nothing elapsed, no drive yet
		tick_after(1, -11520, 32767, 1'b0);     // one millisecond in, small negative torque
		tick_after(1998, 11520, -32768, 1'b1);  // last ramp millisecond, clamped positive torque
		tick_after(1, 0, 0, 1'b0);              // ramp over, active
		tick_after(3, 1920, 0, 1'b1);           // right at the failsafe limit, still balancing
		tick_after(3, -1921, 0, 1'b0);          // one past it, fault
		ask(ACT_CALIBRATE, 1'b0);               // ignored in fault
		tick_after(10, 959, 0, 1'b1);           // below recovery angle, timer armed
		tick_after(100, -960, 0, 1'b1);         // at recovery angle, disarmed
		tick_after(100, 0, 0, 1'b1);            // armed again
		tick_after(3000, -959, 0, 1'b0);        // exactly the recovery time, not enough
		tick_after(1, 0, 0, 1'b1);              // one more millisecond, back to idle
		ask(ACT_START, 1'b1);
		ask(ACT_STOP, 1'b1);                    // stop in the middle of the ramp
		ask(ACT_START, 1'b1);
		tick_after(2500, 16383, 0, 1'b1);       // ramp long over, straight to active
		ask(ACT_STOP, 1'b1);                    // stop from active
		s_axis_tvalid <= 1'b0;
		wait_drained();

		// random phases, each with its own settings, extremes among them
		for (phase = 0; phase < SETTING_PHASES; phase++) begin
			case (phase)
				0: load_settings(int'($urandom_range(0, 23040)) - 11520, $urandom_range(0, 4096),
					$urandom_range(0, 512), $urandom_range(500, 3000), $urandom_range(1, 2000));
				1: load_settings(-11520, 65535, 65535, 0, 65535);
				2: load_settings(11520, 0, 0, 11520, 1);
				3: load_settings(0, 2560, 128, 1920, 0);      // no steps per revolution
				4: load_settings(-16384, 256, 0, 16383, 200); // registers at full width
				default: load_settings($urandom_range(0, 65535), $urandom_range(0, 65535),
					$urandom_range(0, 65535), $urandom_range(0, 11520), $urandom_range(1, 65535));
			endcase
			counted = 0;
			while (counted < ITEMS_PER_PHASE) begin
				run_burst();
				// sender holds off until every result is back
				wait_drained();
			end
		end

		steady_flow = 1'b0;
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("** balance_robot_supervisor_top: PASSED **");
		end else begin
			$display("** balance_robot_supervisor_top: FAILED **");
		end
		$finish;
	end

endmodule
